// ===== src/bglc_pkg.sv =====
package bglc_pkg;

   // Filter weight: new = old + (sample - old) / 2**FILTER_SHIFT
   localparam int unsigned FILTER_SHIFT_DEF = 2;

   // Field widths
   localparam int unsigned NOW_W      = 32;
   localparam int unsigned RAW_W      = 12;
   localparam int unsigned MV_W       = 23;
   localparam int unsigned PCT_W      = 7;
   localparam int unsigned COLOR_W    = 8;
   localparam int unsigned PERIOD_W   = 16;
   localparam int unsigned NOM_W      = 12;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 16;

   // Serial divider sizing
   localparam int unsigned DIV_W     = 32;
   localparam int unsigned DIV_CNT_W = 5;
   localparam int unsigned DEN_W     = 12;
   localparam int unsigned EST_W     = 24;

   // Constant divisions by reciprocal: q = (n * ceil(2**32 / d)) >> 32,
   // exact for every n below 2**28
   localparam int unsigned RC_NUM_W  = 28;
   localparam int unsigned RECIP_W   = 29;
   localparam int unsigned RC_PROD_W = RC_NUM_W + RECIP_W;
   localparam int unsigned RC_SHIFT  = 32;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NOMINAL = 2'd2;

   // Reset values
   localparam logic                RST_ENABLE    = 1'b1;
   localparam logic [PERIOD_W-1:0] RST_PERIOD    = 16'd10;
   localparam logic [NOM_W-1:0]    RST_NOMINAL   = 12'd1200;
   localparam logic [MV_W-1:0]     RST_FILTERED  = 23'd3300;
   localparam logic [PCT_W-1:0]    RST_CHARGE    = 7'd0;
   localparam logic [NOW_W-1:0]    RST_LAST_TIME = 32'd4294967285;

   // Estimate saturation
   localparam logic [MV_W-1:0] MV_MAX = 23'd8388607;

   // Voltage to charge curve breakpoints
   localparam logic [MV_W-1:0] MV_FULL     = 23'd4200;
   localparam logic [MV_W-1:0] MV_KNEE_HI  = 23'd3700;
   localparam logic [MV_W-1:0] MV_KNEE_MID = 23'd3500;
   localparam logic [MV_W-1:0] MV_KNEE_LO  = 23'd3300;
   localparam logic [MV_W-1:0] MV_EMPTY    = 23'd3000;

   // Segment divisors 25, 20, 10 and 30 as reciprocals
   localparam logic [RECIP_W-1:0] PCT_RECIP_HI  = 29'd171798692;
   localparam logic [RECIP_W-1:0] PCT_RECIP_MID = 29'd214748365;
   localparam logic [RECIP_W-1:0] PCT_RECIP_LO  = 29'd429496730;
   localparam logic [RECIP_W-1:0] PCT_RECIP_LOW = 29'd143165577;

   localparam logic [PCT_W-1:0] PCT_BASE_HI  = 7'd60;
   localparam logic [PCT_W-1:0] PCT_BASE_MID = 7'd30;
   localparam logic [PCT_W-1:0] PCT_BASE_LO  = 7'd10;
   localparam logic [PCT_W-1:0] PCT_BASE_LOW = 7'd0;

   // Color bands
   localparam logic [PCT_W-1:0] PCT_BLINK_MAX = 7'd15;
   localparam logic [PCT_W-1:0] PCT_SOLID_MAX = 7'd25;
   localparam logic [PCT_W-1:0] PCT_FADE_MAX  = 7'd50;
   localparam logic [PCT_W-1:0] PCT_FULL      = 7'd100;

   // Fade divisors 25 and 50, blink divisor 25 (400 ms = 16 * 25)
   localparam logic [RECIP_W-1:0] FADE_RECIP_LO = 29'd171798692;
   localparam logic [RECIP_W-1:0] FADE_RECIP_HI = 29'd85899346;
   localparam logic [RECIP_W-1:0] BLINK_RECIP   = 29'd171798692;

   localparam logic [COLOR_W-1:0] COLOR_FULL = 8'd255;

   // Quotient bits of the supply estimate division
   localparam logic [DIV_CNT_W-1:0] EST_COUNT = 5'd24;

   typedef struct packed {
      logic [NOW_W-1:0] now_ms;
      logic [RAW_W-1:0] vref_sample;
   } req_type;

   typedef struct packed {
      logic               frame_send;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
      logic               sampled;
      logic [MV_W-1:0]    supply_mv;
      logic [PCT_W-1:0]   charge_pct;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV_EST,
      ST_PERCENT,
      ST_DIV_PCT,
      ST_COLOR,
      ST_DIV_COLOR,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      DIV_EST,
      DIV_PCT,
      DIV_BLINK,
      DIV_FADE
   } div_op_type;

   typedef enum logic [1:0] {
      CLASS_BLINK,
      CLASS_SOLID,
      CLASS_FADE
   } color_class_type;

   typedef struct packed {
      logic       load_item;
      logic       mark_sample;
      logic       div_start;
      div_op_type div_op;
      logic       update_filter;
      logic       set_pct_direct;
      logic       set_pct_div;
      logic       latch_color;
      logic       load_out;
   } cmd_type;

   typedef struct packed {
      logic            enabled;
      logic            due;
      logic            raw_zero;
      logic            div_done;
      logic            pct_direct;
      color_class_type color_class;
   } status_type;

endpackage

// ===== src/bglc_div.sv =====
module bglc_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [bglc_pkg::DIV_W-1:0]     dividend,
   input  logic [bglc_pkg::DEN_W-1:0]     divisor,
   input  logic [bglc_pkg::DIV_CNT_W-1:0] count,
   output logic                           done,
   output logic [bglc_pkg::DIV_W-1:0]     quotient
);
   import bglc_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DEN_W:0]       rem_shift;
   logic                 fits;

   // One restoring step: bring down the next dividend bit, subtract if it fits
   assign rem_shift = {rem_ff, quo_ff[DIV_W-1]};
   assign fits      = rem_shift >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = count;
         den_in  = divisor;
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? DEN_W'(rem_shift - {1'b0, den_ff}) : rem_shift[DEN_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== src/bglc_datapath.sv =====
module bglc_datapath #(
   parameter int unsigned FILTER_SHIFT = bglc_pkg::FILTER_SHIFT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write,
   input  logic [bglc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bglc_pkg::CSR_DATA_W-1:0] csr_data,
   input  bglc_pkg::req_type               req_data,
   input  bglc_pkg::cmd_type               cmd,
   output bglc_pkg::status_type            status,
   output bglc_pkg::rsp_type               rsp_data
);
   import bglc_pkg::*;

   localparam int unsigned ACC_W = MV_W + FILTER_SHIFT + 1;

   // Configuration
   logic                enable_ff, enable_in;
   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [NOM_W-1:0]    nominal_ff, nominal_in;

   // Item and tracking state
   logic [NOW_W-1:0]    now_ff, now_in;
   logic [RAW_W-1:0]    raw_ff, raw_in;
   logic                sampled_ff, sampled_in;
   logic [NOW_W-1:0]    last_time_ff, last_time_in;
   logic [MV_W-1:0]     filtered_ff, filtered_in;
   logic [PCT_W-1:0]    charge_ff, charge_in;
   logic [COLOR_W-1:0]  color_q_ff, color_q_in;
   rsp_type             rsp_ff, rsp_in;

   // Divider hookup
   logic                 div_start;
   logic [DIV_W-1:0]     div_dividend;
   logic [DEN_W-1:0]     div_divisor;
   logic [DIV_CNT_W-1:0] div_count;
   logic                 div_done;
   logic [DIV_W-1:0]     div_quo;

   // Reciprocal multiplier for the constant divisions
   logic                 rc_start;
   logic [RC_NUM_W-1:0]  rc_num_sel;
   logic [RECIP_W-1:0]   rc_recip_sel;
   logic [RC_NUM_W-1:0]  rc_num_ff, rc_num_in;
   logic [RECIP_W-1:0]   rc_recip_ff, rc_recip_in;
   logic [RC_PROD_W-1:0] rc_prod;
   logic                 rc_busy_ff, rc_busy_in;
   logic                 rc_done_ff, rc_done_in;
   logic [COLOR_W-1:0]   rc_quo_ff, rc_quo_in;

   logic [EST_W-1:0]  est_num;
   logic [MV_W-1:0]   est_sat;
   logic [ACC_W-1:0]  f_ext;
   logic [ACC_W-1:0]  acc;
   logic [MV_W-1:0]   filt_new;

   logic [MV_W-1:0]    d_hi, d_mid, d_lo, d_low;
   logic [9:0]         pct_num;
   logic [RECIP_W-1:0] pct_recip;
   logic [PCT_W-1:0]   pct_base;
   logic               pct_full;

   color_class_type    color_class;
   logic [PCT_W-1:0]   fade_x;
   logic [13:0]        fade_num;
   logic [RECIP_W-1:0] fade_recip;
   logic [NOW_W-1:0]   elapsed;

   // Supply estimate numerator: nominal * 4095
   assign est_num = {nominal_ff, 12'd0} - {12'd0, nominal_ff};

   // Saturate the quotient and run the IIR filter
   assign est_sat  = div_quo[MV_W] ? MV_MAX : div_quo[MV_W-1:0];
   assign f_ext    = ACC_W'(filtered_ff);
   assign acc      = (f_ext << FILTER_SHIFT) - f_ext + ACC_W'(est_sat);
   assign filt_new = acc[FILTER_SHIFT +: MV_W];

   // Pick the charge curve segment
   assign d_hi  = filtered_ff - MV_KNEE_HI;
   assign d_mid = filtered_ff - MV_KNEE_MID;
   assign d_lo  = filtered_ff - MV_KNEE_LO;
   assign d_low = filtered_ff - MV_EMPTY;
   assign pct_full = filtered_ff >= MV_FULL;

   always_comb begin
      if (filtered_ff > MV_KNEE_HI) begin
         pct_num   = {d_hi[8:0], 1'b0};
         pct_recip = PCT_RECIP_HI;
         pct_base  = PCT_BASE_HI;
      end else if (filtered_ff > MV_KNEE_MID) begin
         pct_num   = {d_mid[8:0], 1'b0} + {1'b0, d_mid[8:0]};
         pct_recip = PCT_RECIP_MID;
         pct_base  = PCT_BASE_MID;
      end else if (filtered_ff > MV_KNEE_LO) begin
         pct_num   = {1'b0, d_lo[8:0]};
         pct_recip = PCT_RECIP_LO;
         pct_base  = PCT_BASE_LO;
      end else begin
         pct_num   = {1'b0, d_low[8:0]};
         pct_recip = PCT_RECIP_LOW;
         pct_base  = PCT_BASE_LOW;
      end
   end

   // Classify the color band and set up the fade ratio
   always_comb begin
      if (charge_ff <= PCT_BLINK_MAX) begin
         color_class = CLASS_BLINK;
      end else if (charge_ff <= PCT_SOLID_MAX) begin
         color_class = CLASS_SOLID;
      end else begin
         color_class = CLASS_FADE;
      end
      if (charge_ff <= PCT_FADE_MAX) begin
         fade_x     = charge_ff - PCT_SOLID_MAX;
         fade_recip = FADE_RECIP_LO;
      end else begin
         fade_x     = PCT_FULL - charge_ff;
         fade_recip = FADE_RECIP_HI;
      end
      fade_num = {fade_x[5:0], 8'd0} - {8'd0, fade_x[5:0]};
   end

   // Serial divider only handles the supply estimate
   assign div_start    = cmd.div_start && (cmd.div_op == DIV_EST);
   assign div_dividend = {est_num, 8'd0};
   assign div_divisor  = raw_ff;
   assign div_count    = EST_COUNT;

   bglc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .count    (div_count),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Steer reciprocal multiplier operands
   assign rc_start = cmd.div_start && (cmd.div_op != DIV_EST);

   always_comb begin
      case (cmd.div_op)
         DIV_PCT: begin
            rc_num_sel   = RC_NUM_W'(pct_num);
            rc_recip_sel = pct_recip;
         end
         DIV_BLINK: begin
            // 400 ms phase count: (now / 16) / 25
            rc_num_sel   = now_ff[NOW_W-1:4];
            rc_recip_sel = BLINK_RECIP;
         end
         DIV_FADE: begin
            rc_num_sel   = RC_NUM_W'(fade_num);
            rc_recip_sel = fade_recip;
         end
         default: begin
            rc_num_sel   = '0;
            rc_recip_sel = '0;
         end
      endcase
   end

   // Latch operands, then multiply and keep the low quotient bits
   assign rc_prod = RC_PROD_W'(rc_num_ff) * RC_PROD_W'(rc_recip_ff);

   always_comb begin
      rc_num_in   = rc_num_ff;
      rc_recip_in = rc_recip_ff;
      rc_quo_in   = rc_quo_ff;
      rc_busy_in  = 1'b0;
      rc_done_in  = 1'b0;
      if (rc_start) begin
         rc_num_in   = rc_num_sel;
         rc_recip_in = rc_recip_sel;
         rc_busy_in  = 1'b1;
      end
      if (rc_busy_ff) begin
         rc_quo_in  = rc_prod[RC_SHIFT +: COLOR_W];
         rc_done_in = 1'b1;
      end
   end

   // Report status to the controller
   assign elapsed = now_ff - last_time_ff;

   always_comb begin
      status.enabled     = enable_ff;
      status.due         = elapsed >= {16'd0, period_ff};
      status.raw_zero    = raw_ff == '0;
      status.div_done    = div_done || rc_done_ff;
      status.pct_direct  = pct_full || (filtered_ff <= MV_EMPTY);
      status.color_class = color_class;
   end

   // Register updates
   always_comb begin
      enable_in    = enable_ff;
      period_in    = period_ff;
      nominal_in   = nominal_ff;
      now_in       = now_ff;
      raw_in       = raw_ff;
      sampled_in   = sampled_ff;
      last_time_in = last_time_ff;
      filtered_in  = filtered_ff;
      charge_in    = charge_ff;
      color_q_in   = color_q_ff;
      rsp_in       = rsp_ff;

      if (csr_write) begin
         case (csr_index)
            CSR_ENABLE:  enable_in  = csr_data[0];
            CSR_PERIOD:  period_in  = csr_data[PERIOD_W-1:0];
            CSR_NOMINAL: nominal_in = csr_data[NOM_W-1:0];
            default:     ;
         endcase
      end

      if (cmd.load_item) begin
         now_in     = req_data.now_ms;
         raw_in     = req_data.vref_sample;
         sampled_in = 1'b0;
      end
      if (cmd.mark_sample) begin
         sampled_in   = 1'b1;
         last_time_in = now_ff;
      end
      if (cmd.update_filter) begin
         filtered_in = filt_new;
      end
      if (cmd.set_pct_direct) begin
         charge_in = pct_full ? PCT_FULL : '0;
      end
      if (cmd.set_pct_div) begin
         charge_in = pct_base + rc_quo_ff[PCT_W-1:0];
      end
      if (cmd.latch_color) begin
         color_q_in = rc_quo_ff;
      end

      // Build the outgoing frame
      if (cmd.load_out) begin
         rsp_in.frame_send = enable_ff;
         rsp_in.red        = '0;
         rsp_in.green      = '0;
         rsp_in.blue       = '0;
         rsp_in.sampled    = sampled_ff;
         rsp_in.supply_mv  = filtered_ff;
         rsp_in.charge_pct = charge_ff;
         if (enable_ff) begin
            case (color_class)
               CLASS_BLINK: begin
                  rsp_in.red = color_q_ff[0] ? '0 : COLOR_FULL;
               end
               CLASS_SOLID: begin
                  rsp_in.red = COLOR_FULL;
               end
               CLASS_FADE: begin
                  if (charge_ff <= PCT_FADE_MAX) begin
                     rsp_in.red   = COLOR_FULL;
                     rsp_in.green = color_q_ff;
                  end else begin
                     rsp_in.red   = color_q_ff;
                     rsp_in.green = COLOR_FULL;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= RST_ENABLE;
         period_ff    <= RST_PERIOD;
         nominal_ff   <= RST_NOMINAL;
         last_time_ff <= RST_LAST_TIME;
         filtered_ff  <= RST_FILTERED;
         charge_ff    <= RST_CHARGE;
         rc_busy_ff   <= 1'b0;
         rc_done_ff   <= 1'b0;
      end else begin
         enable_ff    <= enable_in;
         period_ff    <= period_in;
         nominal_ff   <= nominal_in;
         last_time_ff <= last_time_in;
         filtered_ff  <= filtered_in;
         charge_ff    <= charge_in;
         rc_busy_ff   <= rc_busy_in;
         rc_done_ff   <= rc_done_in;
      end
      now_ff      <= now_in;
      raw_ff      <= raw_in;
      sampled_ff  <= sampled_in;
      color_q_ff  <= color_q_in;
      rsp_ff      <= rsp_in;
      rc_num_ff   <= rc_num_in;
      rc_recip_ff <= rc_recip_in;
      rc_quo_ff   <= rc_quo_in;
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== src/bglc_ctrl.sv =====
module bglc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  bglc_pkg::status_type status,
   output bglc_pkg::cmd_type    cmd
);
   import bglc_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!status.enabled) begin
               state_in = ST_FINISH;
            end else if (status.due && !status.raw_zero) begin
               state_in = ST_DIV_EST;
            end else begin
               state_in = ST_COLOR;
            end
         end
         ST_DIV_EST: begin
            if (status.div_done) state_in = ST_PERCENT;
         end
         ST_PERCENT: begin
            state_in = status.pct_direct ? ST_COLOR : ST_DIV_PCT;
         end
         ST_DIV_PCT: begin
            if (status.div_done) state_in = ST_COLOR;
         end
         ST_COLOR: begin
            state_in = (status.color_class == CLASS_SOLID) ? ST_FINISH : ST_DIV_COLOR;
         end
         ST_DIV_COLOR: begin
            if (status.div_done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands
   always_comb begin
      cmd       = '0;
      cmd.div_op = DIV_EST;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
         end
         ST_CHECK: begin
            cmd.mark_sample = status.enabled && status.due;
            cmd.div_start   = status.enabled && status.due && !status.raw_zero;
         end
         ST_DIV_EST: begin
            cmd.update_filter = status.div_done;
         end
         ST_PERCENT: begin
            cmd.set_pct_direct = status.pct_direct;
            cmd.div_start      = !status.pct_direct;
            cmd.div_op         = DIV_PCT;
         end
         ST_DIV_PCT: begin
            cmd.set_pct_div = status.div_done;
         end
         ST_COLOR: begin
            cmd.div_start = status.color_class != CLASS_SOLID;
            cmd.div_op    = (status.color_class == CLASS_BLINK) ? DIV_BLINK : DIV_FADE;
         end
         ST_DIV_COLOR: begin
            cmd.latch_color = status.div_done;
         end
         ST_FINISH: begin
            cmd.load_out = out_free;
         end
         default: ;
      endcase
   end

   // Hold the result until the consumer takes it
   assign rsp_valid_in = cmd.load_out || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== src/battery_gauge_led_color.sv =====
// Flow: a due, nonzero sample runs a 24-step restoring division for the supply
//   estimate, then the charge and the blink or fade level each take a reciprocal
//   multiplication before rsp_valid rises.
// Items: one item is worked on at a time; the output register lets the next
//   item enter while the previous result waits, and a waiting result stalls the next.
// Reset: synchronous, active high; restores registers and filter state, no clear pass.
module battery_gauge_led_color #(
   parameter int unsigned FILTER_SHIFT = bglc_pkg::FILTER_SHIFT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  bglc_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output bglc_pkg::rsp_type               rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bglc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bglc_pkg::CSR_DATA_W-1:0] csr_data
);
   import bglc_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Register writes are always taken
   assign csr_ready = 1'b1;

   bglc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bglc_datapath #(
      .FILTER_SHIFT (FILTER_SHIFT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== src/bglc_checker.sv =====
module bglc_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input bglc_pkg::rsp_type rsp_data
);
   import bglc_pkg::*;

   // Blue channel never lights
   a_blue_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.blue == '0)
      else $error("blue channel driven");

   // No frame means dark LED and no sample
   a_idle_dark: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.frame_send) |->
         (rsp_data.red == '0 && rsp_data.green == '0 && !rsp_data.sampled))
      else $error("color or sample flag without a frame");

   // Charge stays in range
   a_charge_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.charge_pct <= PCT_FULL)
      else $error("charge above full");

   // Solid red and red-yellow bands keep red at full
   a_red_band: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.frame_send && rsp_data.charge_pct > PCT_BLINK_MAX &&
       rsp_data.charge_pct <= PCT_FADE_MAX) |-> rsp_data.red == COLOR_FULL)
      else $error("red not full in low charge band");

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("result dropped or changed while stalled");

endmodule

bind battery_gauge_led_color bglc_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import bglc_pkg::*;

   localparam int unsigned HALF_NS      = 5;
   localparam int unsigned DRAIN_CYCLES = 80;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned TIMEOUT_NS   = 5_000_000;
   localparam int unsigned MAX_SHOWN    = 10;
   localparam int unsigned BLINK_MS     = 400;
   localparam int unsigned ADC_FULL     = 4095;

   // index past the last register, must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data  = '0;

   // gauge predictor state and registers
   logic                gauge_enable  = RST_ENABLE;
   logic [PERIOD_W-1:0] gauge_period  = RST_PERIOD;
   logic [NOM_W-1:0]    gauge_nominal = RST_NOMINAL;
   logic [MV_W-1:0]     gauge_mv      = RST_FILTERED;
   logic [PCT_W-1:0]    gauge_pct     = RST_CHARGE;
   logic [NOW_W-1:0]    gauge_last_ms = RST_LAST_TIME;

   req_type          ticks_pending[$];
   rsp_type          expected_frames[$];
   rsp_type          want;
   logic [NOW_W-1:0] tick_ms = '0;

   bit          req_taken = 1'b0;
   bit          next_valid;
   req_type     next_item;
   bit          idle_on  = 1'b1;
   bit          hold_go  = 1'b0;
   bit          hold_off = 1'b0;
   int unsigned send_gap   = 0;
   int unsigned stall_left = 0;

   int unsigned mismatches = 0;
   int unsigned items_in   = 0;
   int unsigned results    = 0;
   int unsigned samples    = 0;
   int unsigned band_hits[4];

   battery_gauge_led_color dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #HALF_NS clock = ~clock;

   // Advance the gauge by one tick and return the frame it produces
   function automatic rsp_type gauge_step(input req_type tick);
      rsp_type          res;
      longint unsigned  nom;
      longint unsigned  raw;
      longint unsigned  filt;
      longint unsigned  est;
      longint unsigned  acc;
      int unsigned      mv;
      int unsigned      pct;
      logic [NOW_W-1:0] elapsed;
      res = '0;
      if (gauge_enable) begin
         elapsed = tick.now_ms - gauge_last_ms;
         if (elapsed >= gauge_period) begin
            // a zero reading leaves the estimate untouched
            if (tick.vref_sample != '0) begin
               nom  = gauge_nominal;
               raw  = tick.vref_sample;
               filt = gauge_mv;
               est  = nom * ADC_FULL / raw;
               if (est > MV_MAX)
                  est = MV_MAX;
               acc = (filt * ((64'd1 << FILTER_SHIFT_DEF) - 1) + est) >> FILTER_SHIFT_DEF;
               gauge_mv = MV_W'(acc);
               // piecewise-linear discharge curve
               mv = gauge_mv;
               if (mv >= MV_FULL)
                  pct = 100;
               else if (mv <= MV_EMPTY)
                  pct = 0;
               else if (mv > MV_KNEE_HI)
                  pct = 60 + (mv - MV_KNEE_HI) * 40 / 500;
               else if (mv > MV_KNEE_MID)
                  pct = 30 + (mv - MV_KNEE_MID) * 30 / 200;
               else if (mv > MV_KNEE_LO)
                  pct = 10 + (mv - MV_KNEE_LO) * 20 / 200;
               else
                  pct = (mv - MV_EMPTY) * 10 / 300;
               gauge_pct = PCT_W'(pct);
            end
            gauge_last_ms = tick.now_ms;
            res.sampled = 1'b1;
         end
         // pick the color band from the current charge
         res.frame_send = 1'b1;
         pct = gauge_pct;
         if (pct <= PCT_BLINK_MAX) begin
            if ((tick.now_ms / BLINK_MS) % 2 == 0)
               res.red = COLOR_FULL;
         end else if (pct <= PCT_SOLID_MAX) begin
            res.red = COLOR_FULL;
         end else if (pct <= PCT_FADE_MAX) begin
            res.red   = COLOR_FULL;
            res.green = COLOR_W'((pct - PCT_SOLID_MAX) * 255 / 25);
         end else begin
            res.green = COLOR_FULL;
            res.red   = COLOR_W'((PCT_FULL - pct) * 255 / 50);
         end
      end
      res.supply_mv  = gauge_mv;
      res.charge_pct = gauge_pct;
      return res;
   endfunction

   task automatic check_field(input string label, input logic [31:0] exp_val,
                              input logic [31:0] got_val);
      if (exp_val !== got_val) begin
         mismatches++;
         if (mismatches <= MAX_SHOWN)
            $display("%0t: result %0d field %s: expected %0d, got %0d",
                     $time, results, label, exp_val, got_val);
      end
   endtask

   // Monitor: track register writes, predict accepted items, check results
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ENABLE:  gauge_enable  = csr_data[0];
               CSR_PERIOD:  gauge_period  = csr_data[PERIOD_W-1:0];
               CSR_NOMINAL: gauge_nominal = csr_data[NOM_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            req_taken = 1'b1;
            expected_frames.push_back(gauge_step(req_data));
            items_in++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_frames.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_SHOWN)
                  $display("%0t: result %0d arrived with nothing expected", $time, results);
            end else begin
               want = expected_frames.pop_front();
               check_field("frame_send", want.frame_send, rsp_data.frame_send);
               check_field("red",        want.red,        rsp_data.red);
               check_field("green",      want.green,      rsp_data.green);
               check_field("blue",       want.blue,       rsp_data.blue);
               check_field("sampled",    want.sampled,    rsp_data.sampled);
               check_field("supply_mv",  want.supply_mv,  rsp_data.supply_mv);
               check_field("charge_pct", want.charge_pct, rsp_data.charge_pct);
               if (want.sampled)
                  samples++;
               if (want.frame_send) begin
                  if (want.charge_pct <= PCT_BLINK_MAX)
                     band_hits[0]++;
                  else if (want.charge_pct <= PCT_SOLID_MAX)
                     band_hits[1]++;
                  else if (want.charge_pct <= PCT_FADE_MAX)
                     band_hits[2]++;
                  else
                     band_hits[3]++;
               end
            end
            results++;
         end
      end
   end

   // Driver: hold the item until taken, then offer the next one or idle
   always @(negedge clock) begin
      next_valid = req_valid;
      next_item  = req_data;
      if (req_taken)
         next_valid = 1'b0;
      req_taken = 1'b0;
      if (!next_valid && !reset) begin
         if (send_gap != 0) begin
            send_gap--;
         end else if (ticks_pending.size() != 0) begin
            if (idle_on && $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(1, 13);
            end else begin
               next_item  = ticks_pending.pop_front();
               next_valid = 1'b1;
            end
         end
      end
      req_valid <= next_valid;
      req_data  <= next_item;
   end

   // Receiver: stall in random bursts and during the long hold-off
   always @(negedge clock) begin
      if (stall_left != 0)
         stall_left--;
      else if (idle_on && $urandom_range(0, 7) == 0)
         stall_left = $urandom_range(1, 13);
      rsp_ready <= !reset && !hold_off && stall_left == 0;
   end

   // Long hold-off on the result side so the block backs up
   initial begin
      wait (hold_go);
      @(posedge clock);
      hold_off = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off = 1'b0;
   end

   task automatic add_tick(input logic [NOW_W-1:0] now, input logic [RAW_W-1:0] raw);
      req_type tick;
      tick.now_ms      = now;
      tick.vref_sample = raw;
      tick_ms          = now;
      ticks_pending.push_back(tick);
   endtask

   // Queue ticks that track a slowly moving supply target, with some noise
   task automatic add_random_ticks(input int count, input int unsigned period,
                                   input int unsigned nominal);
      int unsigned target;
      int unsigned raw;
      int unsigned seg_left;
      int unsigned pick;
      seg_left = 0;
      target   = 3600;
      for (int i = 0; i < count; i++) begin
         if (seg_left == 0) begin
            target   = $urandom_range(2850, 4350);
            seg_left = $urandom_range(8, 40);
         end
         seg_left--;
         pick = $urandom_range(0, 99);
         raw  = nominal * ADC_FULL / target + $urandom_range(0, 6);
         raw  = (raw > 3) ? raw - 3 : 1;
         if (raw > ADC_FULL)
            raw = ADC_FULL;
         tick_ms = tick_ms + $urandom_range(0, period * 2 + 2);
         if (pick < 6)
            raw = $urandom_range(0, ADC_FULL);
         else if (pick < 9)
            raw = 0;
         else if (pick < 12)
            tick_ms = $urandom;
         else if (pick < 14)
            tick_ms = 32'hFFFF_FFFF - $urandom_range(0, period + 2);
         add_tick(tick_ms, raw[RAW_W-1:0]);
      end
   endtask

   // Wait until everything queued has been taken and answered
   task automatic wait_idle();
      do @(posedge clock);
      while (ticks_pending.size() != 0 || req_valid || expected_frames.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock);
      while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Drain, then write all registers with junk in the unused upper bits
   task automatic apply_config(input logic en, input logic [PERIOD_W-1:0] period,
                               input logic [NOM_W-1:0] nominal);
      logic [31:0] junk;
      junk = $urandom;
      wait_idle();
      csr_write(CSR_ENABLE, {junk[15:1], en});
      csr_write(CSR_PERIOD, period);
      csr_write(CSR_NOMINAL, {junk[15:12], nominal});
   endtask

   initial begin
      int unsigned period;
      int unsigned nominal;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: forced first sample, early tick, zero reading, blink phases
      add_tick(32'd0, 12'd1365);
      add_tick(32'd5, 12'd1365);
      add_tick(32'd10, 12'd0);
      add_tick(32'd19, 12'd4095);
      add_tick(32'd20, 12'd4095);
      add_tick(32'd399, 12'd4095);
      add_tick(32'd400, 12'd4095);
      add_tick(32'd799, 12'd4095);
      add_tick(32'd800, 12'd4095);
      add_tick(32'd1199, 12'hAAA);
      add_tick(32'd1200, 12'h555);
      // time wrap: not due one ms short of the period, then due with a tiny reading
      add_tick(32'hFFFF_FFFF, 12'd4095);
      add_tick(32'd8, 12'd4095);
      add_tick(32'd9, 12'd1);
      add_tick(32'h8000_0000, 12'd1365);

      // Zero period and zero nominal, plus a write to an unused index
      apply_config(1'b1, 16'd0, 12'd0);
      csr_write(CSR_SPARE, 16'hFFFF);
      for (int i = 0; i < 10; i++)
         add_tick(tick_ms, (i % 3 == 0) ? 12'd0 : RAW_W'($urandom));

      // Disabled: no frame, no sample, state held
      apply_config(1'b0, 16'hFFFF, 12'hFFF);
      add_random_ticks(15, 65535, 4095);

      // Longest period, largest nominal, saturated estimate
      apply_config(1'b1, 16'hFFFF, 12'hFFF);
      add_random_ticks(30, 65535, 4095);
      add_tick(tick_ms + 32'd70000, 12'd1);
      add_tick(tick_ms + 32'd70000, 12'd1);

      // Default settings, bulk of the random traffic
      apply_config(1'b1, 16'd10, 12'd1200);
      add_random_ticks(380, 10, 1200);

      // Shortest period while the result side holds off for a long stretch
      apply_config(1'b1, 16'd1, 12'd1200);
      add_random_ticks(200, 1, 1200);
      hold_go = 1'b1;

      // Random settings, no idling on either side
      period  = $urandom_range(2, 50);
      nominal = $urandom_range(900, 1500);
      apply_config(1'b1, PERIOD_W'(period), NOM_W'(nominal));
      idle_on = 1'b0;
      add_random_ticks(230, period, nominal);

      wait_idle();
      $display("Covered %0d ticks over seven register settings: %0d results, %0d samples.",
               items_in, results, samples);
      $display("Frames per band: blink %0d, solid red %0d, red-yellow %0d, yellow-green %0d.",
               band_hits[0], band_hits[1], band_hits[2], band_hits[3]);
      if (mismatches == 0 && expected_frames.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #TIMEOUT_NS;
      $display("Timeout with %0d results still expected", expected_frames.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
